// ----- hw/rtl/perspective_projection_to_screen_macros.svh -----
// Assertion macros for the perspective projection block.
// Taken in by the top module, which checks its own pipeline behavior.
`ifndef PERSPECTIVE_PROJECTION_TO_SCREEN_MACROS_SVH
`define PERSPECTIVE_PROJECTION_TO_SCREEN_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PPTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppts check failed");

// Next-cycle implication, checked during reset as well.
`define PPTS_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ppts check failed");

`endif

// ----- hw/rtl/ppts_pkg.sv -----
// Shared types, widths and codes for the perspective projection block.
// No dependencies.
`timescale 1ns / 1ps
package ppts_pkg;

  localparam int unsigned COORD_W   = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned HOM_W     = 50;  // homogeneous x, y, z, w
  localparam int unsigned QUO_W     = 48;  // quotient bits below the clamp
  localparam int unsigned Q_W       = 50;  // signed ratio, magnitude up to 2^48
  localparam int unsigned SCR_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PROD_W    = 65;

  typedef enum logic {
    REQ_COEF  = 1'b0,
    REQ_POINT = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_t;

  localparam logic [SCR_W-1:0] WIDTH_RST  = 13'd2560;
  localparam logic [SCR_W-1:0] HEIGHT_RST = 13'd1600;

  typedef logic signed [HOM_W-1:0] hom_t;
  typedef logic signed [Q_W-1:0]   ratio_t;

  typedef struct packed {
    logic valid;
    logic w_zero;
  } ctl_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(signed'(32'sh7fffffff));
    lo = PROD_W'(signed'(32'sh80000000));
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage

// ----- hw/rtl/ppts_in_if.sv -----
// Input channel of the projection block: coefficient writes and points.
// Depends on nothing.
`timescale 1ns / 1ps
interface ppts_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [3:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source(output valid, req_type, coef_index, coef_value, point_x, point_y, point_z,
                 input ready);
  modport sink(input valid, req_type, coef_index, coef_value, point_x, point_y, point_z,
               output ready);
endinterface

// ----- hw/rtl/ppts_out_if.sv -----
// Result channel of the projection block: screen position, depth, zero-w flag.
// Depends on nothing.
`timescale 1ns / 1ps
interface ppts_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth;
  logic               w_is_zero;

  modport source(output valid, screen_x, screen_y, depth, w_is_zero, input ready);
  modport sink(input valid, screen_x, screen_y, depth, w_is_zero, output ready);
endinterface

// ----- hw/rtl/ppts_xform.sv -----
// Matrix store and point-times-matrix stages (products, then column sums).
// Depends on ppts_pkg.
`timescale 1ns / 1ps
module ppts_xform (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  pt_fire,
  input  logic                                  wr_en,
  input  logic [3:0]                            wr_idx,
  input  logic signed [ppts_pkg::COORD_W-1:0]   wr_val,
  input  logic signed [ppts_pkg::COORD_W-1:0]   px,
  input  logic signed [ppts_pkg::COORD_W-1:0]   py,
  input  logic signed [ppts_pkg::COORD_W-1:0]   pz,
  output ppts_pkg::ctl_t                        ctl,
  output ppts_pkg::hom_t                        hx,
  output ppts_pkg::hom_t                        hy,
  output ppts_pkg::hom_t                        hz,
  output ppts_pkg::hom_t                        hw
);

  logic signed [ppts_pkg::COORD_W-1:0]   m_r [16];
  logic signed [2*ppts_pkg::COORD_W-1:0] prod_r [12];
  logic signed [ppts_pkg::COORD_W-1:0]   tr_r [4];
  logic                                  v1_r;
  ppts_pkg::hom_t                        col_nxt [4];
  ppts_pkg::hom_t                        col_r [4];
  logic                                  v2_r;
  logic signed [ppts_pkg::COORD_W-1:0]   pt [3];

  assign pt[0] = px;
  assign pt[1] = py;
  assign pt[2] = pz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        m_r[i] <= '0;
      end
    end else if (wr_en) begin
      m_r[wr_idx] <= wr_val;
    end
  end

  // Stage 1: twelve products plus the translation row.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[r*4+c] <= 64'(pt[r]) * 64'(m_r[r*4+c]);
        end
      end
      for (int c = 0; c < 4; c++) begin
        tr_r[c] <= m_r[12+c];
      end
    end
  end

  // Stage 2: floor each product to Q.16 and sum the column.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      col_nxt[c] = ppts_pkg::HOM_W'(tr_r[c])
                 + ppts_pkg::HOM_W'(prod_r[c]   >>> ppts_pkg::FRAC_W)
                 + ppts_pkg::HOM_W'(prod_r[4+c] >>> ppts_pkg::FRAC_W)
                 + ppts_pkg::HOM_W'(prod_r[8+c] >>> ppts_pkg::FRAC_W);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        col_r[c] <= col_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= pt_fire;
      v2_r <= v1_r;
    end
  end

  assign ctl.valid  = v2_r;
  assign ctl.w_zero = (col_r[3] == '0);
  assign hx = col_r[0];
  assign hy = col_r[1];
  assign hz = col_r[2];
  assign hw = col_r[3];

endmodule

// ----- hw/rtl/ppts_div.sv -----
// Pipelined signed Q.16 divider: one quotient bit per stage, clamp at 2^48.
// Depends on ppts_pkg.
`timescale 1ns / 1ps
module ppts_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_tag,
  input  ppts_pkg::hom_t       num,
  input  ppts_pkg::hom_t       den,
  output logic                 out_valid,
  output logic                 out_tag,
  output ppts_pkg::ratio_t     quo
);

  localparam int unsigned N  = ppts_pkg::QUO_W;
  localparam int unsigned DW = ppts_pkg::HOM_W;
  localparam int unsigned LW = ppts_pkg::COORD_W + ppts_pkg::FRAC_W;
  localparam int unsigned Q_MAG_W = ppts_pkg::Q_W;

  logic [DW-1:0] an;
  logic [DW-1:0] ad;
  logic [DW-1:0] rem0;

  logic [DW-1:0] rem_r [N+1];
  logic [LW-1:0] low_r [N+1];
  logic [N-1:0]  q_r   [N+1];
  logic [DW-1:0] ad_r  [N+1];
  logic          neg_r [N+1];
  logic          ovf_r [N+1];
  logic          tag_r [N+1];
  logic          v_r   [N+1];

  logic [DW:0]   trial [N];
  logic          qbit  [N];

  logic [Q_MAG_W-1:0] mag;

  ppts_pkg::ratio_t quo_r;
  logic             vo_r;
  logic             tago_r;

  assign an   = num[DW-1] ? DW'(-num) : DW'(num);
  assign ad   = den[DW-1] ? DW'(-den) : DW'(den);
  assign rem0 = an >> ppts_pkg::COORD_W;

  // Stage 0: magnitudes, sign and the integer-part overflow test.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem0;
      low_r[0] <= {an[ppts_pkg::COORD_W-1:0], ppts_pkg::FRAC_W'(0)};
      q_r[0]   <= '0;
      ad_r[0]  <= ad;
      neg_r[0] <= num[DW-1] ^ den[DW-1];
      ovf_r[0] <= (rem0 >= ad);
      tag_r[0] <= in_tag;
    end
  end

  always_comb begin
    for (int k = 0; k < N; k++) begin
      trial[k] = {rem_r[k], low_r[k][LW-1]};
      qbit[k]  = (trial[k] >= {1'b0, ad_r[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_r[k+1] <= qbit[k] ? DW'(trial[k] - {1'b0, ad_r[k]}) : DW'(trial[k]);
        low_r[k+1] <= {low_r[k][LW-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][N-2:0], qbit[k]};
        ad_r[k+1]  <= ad_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) begin
        v_r[k] <= 1'b0;
      end
      vo_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 0; k < N; k++) begin
        v_r[k+1] <= v_r[k];
      end
      vo_r <= v_r[N];
    end
  end

  assign mag = ovf_r[N] ? (Q_MAG_W'(1) << N) : Q_MAG_W'(q_r[N]);

  // Final stage: apply clamp and sign.
  always_ff @(posedge clk) begin
    if (en) begin
      quo_r  <= neg_r[N] ? -ppts_pkg::ratio_t'(mag) : ppts_pkg::ratio_t'(mag);
      tago_r <= tag_r[N];
    end
  end

  assign out_valid = vo_r;
  assign out_tag   = tago_r;
  assign quo       = quo_r;

endmodule

// ----- hw/rtl/ppts_scale.sv -----
// Viewport scaling and saturation stages, plus the result register.
// Depends on ppts_pkg.
`timescale 1ns / 1ps
module ppts_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  ppts_pkg::ctl_t                      ctl,
  input  ppts_pkg::ratio_t                    qx,
  input  ppts_pkg::ratio_t                    qy,
  input  ppts_pkg::ratio_t                    qz,
  input  logic [ppts_pkg::SCR_W-1:0]          width,
  input  logic [ppts_pkg::SCR_W-1:0]          height,
  output logic                                out_valid,
  output logic signed [ppts_pkg::COORD_W-1:0] sx,
  output logic signed [ppts_pkg::COORD_W-1:0] sy,
  output logic signed [ppts_pkg::COORD_W-1:0] dz,
  output logic                                wz
);

  localparam int unsigned PW = ppts_pkg::PROD_W;
  localparam int unsigned TW = ppts_pkg::Q_W + 1;

  logic signed [TW-1:0] tx;
  logic signed [TW-1:0] ty;
  logic signed [PW-1:0] px_r;
  logic signed [PW-1:0] py_r;
  ppts_pkg::ratio_t     qz_r;
  logic                 wz_r;
  logic                 va_r;

  logic signed [ppts_pkg::COORD_W-1:0] sx_r;
  logic signed [ppts_pkg::COORD_W-1:0] sy_r;
  logic signed [ppts_pkg::COORD_W-1:0] dz_r;
  logic                                wzo_r;
  logic                                vo_r;

  assign tx = TW'(signed'(32'sh10000)) + TW'(qx);
  assign ty = TW'(signed'(32'sh10000)) - TW'(qy);

  // Stage A: scale by the viewport size.
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= PW'(tx) * PW'(signed'({1'b0, width}));
      py_r <= PW'(ty) * PW'(signed'({1'b0, height}));
      qz_r <= qz;
      wz_r <= ctl.w_zero;
    end
  end

  // Stage B: halve, saturate, force zero on a zero w.
  always_ff @(posedge clk) begin
    if (en) begin
      if (wz_r) begin
        sx_r <= '0;
        sy_r <= '0;
        dz_r <= '0;
      end else begin
        sx_r <= ppts_pkg::sat32(px_r >>> 1);
        sy_r <= ppts_pkg::sat32(py_r >>> 1);
        dz_r <= ppts_pkg::sat32(PW'(qz_r));
      end
      wzo_r <= wz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      va_r <= ctl.valid;
      vo_r <= va_r;
    end
  end

  assign out_valid = vo_r;
  assign sx = sx_r;
  assign sy = sy_r;
  assign dz = dz_r;
  assign wz = wzo_r;

endmodule

// ----- hw/rtl/perspective_projection_to_screen.sv -----
// Perspective projection block: takes coefficient writes and points on in_item,
// gives screen x, screen y, depth and a zero-w flag on out_item.
// An item with req_type 0 writes one of 16 matrix coefficients and gives no result;
// the write takes effect for any point accepted in a later cycle.
// An item with req_type 1 is a point; its result passes through the registered stages
// (2 matrix stages, 50 divider stages, 2 scaling stages) before it leaves.
// Throughput is one item per cycle while not stalled: the divider gives one quotient
// bit per stage, so the 48 quotient bits set most of the latency, not the rate.
// in_item.ready is high whenever the result register is empty or being taken;
// while the receiver stalls with a result waiting, the whole pipeline holds and
// nothing is lost or repeated.
// Reset clears the matrix to zero, sets the viewport to 2560 x 1600 and empties the
// pipeline. cfg_we with cfg_index writes screen_width (0) or screen_height (1);
// write them only while no point is in flight.
// Depends on ppts_pkg, ppts_in_if, ppts_out_if, ppts_xform, ppts_div, ppts_scale
// and the macros header.
`timescale 1ns / 1ps
`include "perspective_projection_to_screen_macros.svh"
module perspective_projection_to_screen (
  input  logic                              clk,
  input  logic                              rst_n,
  ppts_in_if.sink                           in_item,
  ppts_out_if.source                        out_item,
  input  logic                              cfg_we,
  input  logic [ppts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppts_pkg::SCR_W-1:0]        cfg_wdata
);

  logic                        en;
  logic                        accept;
  logic                        wr_en;
  logic                        pt_fire;
  logic [ppts_pkg::SCR_W-1:0]  width_r;
  logic [ppts_pkg::SCR_W-1:0]  height_r;

  ppts_pkg::ctl_t   xf_ctl;
  ppts_pkg::hom_t   hx;
  ppts_pkg::hom_t   hy;
  ppts_pkg::hom_t   hz;
  ppts_pkg::hom_t   hw;
  ppts_pkg::ctl_t   dv_ctl;
  ppts_pkg::ratio_t qx;
  ppts_pkg::ratio_t qy;
  ppts_pkg::ratio_t qz;

  assign en      = !out_item.valid || out_item.ready;
  assign accept  = in_item.valid && en;
  assign wr_en   = accept && (in_item.req_type == ppts_pkg::REQ_COEF);
  assign pt_fire = accept && (in_item.req_type == ppts_pkg::REQ_POINT);
  assign in_item.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ppts_pkg::WIDTH_RST;
      height_r <= ppts_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ppts_pkg::CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        ppts_pkg::CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ppts_xform u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .pt_fire (pt_fire),
    .wr_en   (wr_en),
    .wr_idx  (in_item.coef_index),
    .wr_val  (in_item.coef_value),
    .px      (in_item.point_x),
    .py      (in_item.point_y),
    .pz      (in_item.point_z),
    .ctl     (xf_ctl),
    .hx      (hx),
    .hy      (hy),
    .hz      (hz),
    .hw      (hw)
  );

  // The x lane carries valid and the zero-w flag for all three.
  ppts_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (xf_ctl.valid),
    .in_tag    (xf_ctl.w_zero),
    .num       (hx),
    .den       (hw),
    .out_valid (dv_ctl.valid),
    .out_tag   (dv_ctl.w_zero),
    .quo       (qx)
  );

  ppts_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (xf_ctl.valid),
    .in_tag    (1'b0),
    .num       (hy),
    .den       (hw),
    .out_valid (),
    .out_tag   (),
    .quo       (qy)
  );

  ppts_div u_div_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (xf_ctl.valid),
    .in_tag    (1'b0),
    .num       (hz),
    .den       (hw),
    .out_valid (),
    .out_tag   (),
    .quo       (qz)
  );

  ppts_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (dv_ctl),
    .qx        (qx),
    .qy        (qy),
    .qz        (qz),
    .width     (width_r),
    .height    (height_r),
    .out_valid (out_item.valid),
    .sx        (out_item.screen_x),
    .sy        (out_item.screen_y),
    .dz        (out_item.depth),
    .wz        (out_item.w_is_zero)
  );

  `PPTS_ASSERT_IMP(a_wzero_outputs, clk, rst_n, out_item.valid && out_item.w_is_zero, out_item.screen_x == 0 && out_item.screen_y == 0 && out_item.depth == 0)
  `PPTS_ASSERT_IMP(a_zero_width, clk, rst_n, out_item.valid && width_r == 0, out_item.screen_x == 0)
  `PPTS_ASSERT_IMP(a_zero_height, clk, rst_n, out_item.valid && height_r == 0, out_item.screen_y == 0)
  `PPTS_ASSERT_NXT(a_reset_empty, clk, !rst_n, !out_item.valid && !dv_ctl.valid && !xf_ctl.valid)

endmodule

// ----- dv/tb_perspective_projection_to_screen.sv -----
`timescale 1ns / 1ps
// Testbench for perspective_projection_to_screen: drives coefficient writes and points
// under varied idling, predicts each screen result and checks it in order.
// Depends on ppts_pkg, ppts_in_if, ppts_out_if and the block itself.

typedef struct {
  logic               req_type;
  logic [3:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
} vtx_item_t;

typedef struct {
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth;
  logic               w_is_zero;
} screen_pt_t;

class projection_scoreboard;
  logic signed [31:0] coef[16];
  longint             view_w;
  longint             view_h;
  screen_pt_t         pending_pts[$];
  int                 mismatches;

  function new();
    foreach (coef[i]) coef[i] = '0;
    view_w = ppts_pkg::WIDTH_RST;
    view_h = ppts_pkg::HEIGHT_RST;
    mismatches = 0;
  endfunction

  function void set_view(ppts_pkg::cfg_idx_t idx, logic [12:0] val);
    if (idx == ppts_pkg::CFG_SCREEN_WIDTH) view_w = val;
    else view_h = val;
  endfunction

  function longint col_dot(longint p[3], int col);
    longint acc;
    acc = coef[12 + col];
    for (int r = 0; r < 3; r++) acc += (p[r] * longint'(coef[r * 4 + col])) >>> 16;
    return acc;
  endfunction

  // Q.16 ratio truncated toward zero; magnitude clamped at 2^48
  function longint ratio_q16(longint num, longint den);
    longint unsigned an, ad, ip, mag;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    ip = an / ad;
    if (ip >= (64'd1 << 32)) mag = 64'd1 << 48;
    else mag = (ip << 16) + ((an % ad) << 16) / ad;
    return ((num < 0) != (den < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function void note_input(vtx_item_t it);
    longint p[3];
    longint x, y, z, w;
    screen_pt_t r;
    if (it.req_type == ppts_pkg::REQ_COEF) begin
      coef[it.coef_index] = it.coef_value;
      return;
    end
    p[0] = it.px;
    p[1] = it.py;
    p[2] = it.pz;
    x = col_dot(p, 0);
    y = col_dot(p, 1);
    z = col_dot(p, 2);
    w = col_dot(p, 3);
    if (w == 0) begin
      r = '{0, 0, 0, 1'b1};
    end else begin
      r.screen_x = clamp32(((65536 + ratio_q16(x, w)) * view_w) >>> 1);
      r.screen_y = clamp32(((65536 - ratio_q16(y, w)) * view_h) >>> 1);
      r.depth = clamp32(ratio_q16(z, w));
      r.w_is_zero = 1'b0;
    end
    pending_pts.push_back(r);
  endfunction

  function void check(screen_pt_t got);
    screen_pt_t exp_pt;
    if (pending_pts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: sx=%0d sy=%0d d=%0d wz=%0b",
                                     got.screen_x, got.screen_y, got.depth, got.w_is_zero);
      return;
    end
    exp_pt = pending_pts.pop_front();
    if (got.screen_x !== exp_pt.screen_x || got.screen_y !== exp_pt.screen_y ||
        got.depth !== exp_pt.depth || got.w_is_zero !== exp_pt.w_is_zero) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp sx=%0d sy=%0d d=%0d wz=%0b, got sx=%0d sy=%0d d=%0d wz=%0b",
                 exp_pt.screen_x, exp_pt.screen_y, exp_pt.depth, exp_pt.w_is_zero,
                 got.screen_x, got.screen_y, got.depth, got.w_is_zero);
    end
  endfunction
endclass

module tb_perspective_projection_to_screen;

  localparam int DRAIN_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  ppts_in_if  in_if();
  ppts_out_if out_if();

  projection_scoreboard sb = new();
  int src_idle = 0;
  int rcv_stall = 0;
  int hold_cycles = 0;

  always #2 clk = ~clk;

  perspective_projection_to_screen dut (
    .clk(clk), .rst_n(rst_n), .in_item(in_if), .out_item(out_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = ppts_pkg::REQ_COEF;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.point_z = '0;
    out_if.ready = 1'b0;
  end

  // Receiver: stall at random, hold off entirely while hold_cycles runs down
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check('{out_if.screen_x, out_if.screen_y, out_if.depth, out_if.w_is_zero});
  end

  task automatic send_item(vtx_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.req_type = it.req_type;
    in_if.coef_index = it.coef_index;
    in_if.coef_value = it.coef_value;
    in_if.point_x = it.px;
    in_if.point_y = it.py;
    in_if.point_z = it.pz;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(it);
  endtask

  task automatic send_coef(int idx, logic signed [31:0] val);
    send_item('{ppts_pkg::REQ_COEF, 4'(idx), val, $urandom, $urandom, $urandom});
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    send_item('{ppts_pkg::REQ_POINT, 4'($urandom_range(15)), $urandom, x, y, z});
  endtask

  // Wait out in-flight points, then a margin for trailing coefficient writes
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_view(ppts_pkg::cfg_idx_t idx, logic [12:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.set_view(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      3:       return 32'($urandom_range(255)) - 128;
      default: return 32'($urandom_range(32'h00800000)) - 32'sh00400000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return 0;
      default: return 32'($urandom_range(32'h00080000)) - 32'sh00040000;
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) send_coef($urandom_range(15), rand_coef());
      else send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset matrix is all zero, so w is zero
    send_point(32'sh00010000, 32'sh7fffffff, 32'sh80000000);
    // Identity with w taken from z
    send_coef(0, 32'sh00010000);
    send_coef(5, 32'sh00010000);
    send_coef(10, 32'sh00010000);
    send_coef(11, 32'sh00010000);
    send_point(32'sh00008000, 32'shffff8000, 32'sh00010000);
    send_point(32'sh00010000, 32'sh00010000, 32'sh00020000);
    send_point(0, 0, 0);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh00010000);
    send_point(32'sh80000000, 32'sh7fffffff, 32'shffff0000);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh00000001);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_coef(15, 32'sh7fffffff);
    send_coef(3, 32'sh80000000);
    send_point(32'sh00010000, 32'sh00030000, 32'shfffd0000);
    send_coef(12, 32'sh80000000);
    send_coef(13, 32'sh7fffffff);
    send_point(0, 0, 0);
    drain();

    // Zero viewport sizes and maximum sizes
    write_view(ppts_pkg::CFG_SCREEN_WIDTH, 13'd0);
    write_view(ppts_pkg::CFG_SCREEN_HEIGHT, 13'd8191);
    send_coef(3, 0);
    send_coef(15, 32'sh00010000);
    send_point(32'sh00020000, 32'shfffe0000, 32'sh00010000);
    send_point(32'sh7fffffff, 32'sh80000000, 0);
    drain();

    // Back to back, with one long receiver hold so the pipeline fills
    write_view(ppts_pkg::CFG_SCREEN_WIDTH, 13'd2560);
    write_view(ppts_pkg::CFG_SCREEN_HEIGHT, 13'd1600);
    src_idle = 0;
    rcv_stall = 0;
    hold_cycles = 300;
    random_phase(150);
    drain();

    write_view(ppts_pkg::CFG_SCREEN_WIDTH, 13'd8191);
    write_view(ppts_pkg::CFG_SCREEN_HEIGHT, 13'd0);
    src_idle = 84;
    random_phase(150);
    drain();

    write_view(ppts_pkg::CFG_SCREEN_WIDTH, 13'd1);
    write_view(ppts_pkg::CFG_SCREEN_HEIGHT, 13'd8191);
    src_idle = 0;
    rcv_stall = 84;
    random_phase(150);
    drain();

    write_view(ppts_pkg::CFG_SCREEN_WIDTH, 13'($urandom));
    write_view(ppts_pkg::CFG_SCREEN_HEIGHT, 13'($urandom));
    src_idle = 30;
    rcv_stall = 30;
    random_phase(150);
    drain();

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end
endmodule
